@@ hdl/hcb_pkg.sv @@
// Shared types and constants for the Huffman code builder and encoder.
`timescale 1ns / 1ps
`default_nettype none
package hcb_pkg;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int MAX_CODE_BITS_DEF = 64;
    localparam int SYMBOLS_DEF       = 256;
    localparam int CODE_W  = 64;
    localparam int LEN_W   = 7;
    localparam int ALPHA_W = 9;
    localparam int PAY_W   = 47;
    localparam int DEP_W   = 8;
    localparam int SUM_W   = 49;
    localparam logic [PAY_W-1:0] PAY_MAX = {PAY_W{1'b1}};

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ABSENT    = 2'd1;
    localparam logic [1:0] STAT_NOT_BUILT = 2'd2;

    typedef enum logic [1:0] {
        CMD_COUNT, CMD_BUILD, CMD_ENCODE, CMD_READ
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_value;
        logic [7:0] entry_index;
    } t_in;

    typedef struct packed {
        logic [7:0]         symbol;
        logic [LEN_W-1:0]   code_length;
        logic [CODE_W-1:0]  code_bits;
        logic [ALPHA_W-1:0] alphabet_size;
        logic [PAY_W-1:0]   payload_bits;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] byte_value;
        logic [7:0] entry_index;
        logic       in_range;
    } t_job;

    typedef enum logic [4:0] {
        S_IDLE, S_CNT_RD, S_CNT_WR, S_E_RD, S_E_GO, S_R_RD, S_R_S, S_R_C,
        S_B_RD, S_B_CHK, S_C_RUN, S_B_WR, S_M_INIT, S_M_RD, S_M_A, S_M_RD2,
        S_M_B, S_D_INIT, S_D_RD, S_D_P, S_D_Q, S_L_RD, S_L_S, S_L_H, S_L_ADD,
        S_EMIT
    } t_state;
endpackage
`default_nettype wire

@@ hdl/hcb_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ hdl/hcb_fifo.sv @@
// Two-entry queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`default_nettype none
module hcb_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

@@ hdl/hcb_front.sv @@
// Front end: accepts command transactions, classifies them and queues them.
`timescale 1ns / 1ps
`default_nettype none
module hcb_front #(
    parameter int SYMBOLS = hcb_pkg::SYMBOLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  hcb_pkg::t_in  i_item,
    input  logic          i_pop,
    output logic          o_empty,
    output hcb_pkg::t_job o_job
);
    hcb_pkg::t_job w_job;
    logic [$bits(hcb_pkg::t_job)-1:0] w_qdata;

    always_comb begin
        w_job.cmd         = hcb_pkg::t_cmd'(i_item.command);
        w_job.byte_value  = i_item.byte_value;
        w_job.entry_index = i_item.entry_index;
        w_job.in_range    = ({1'b0, i_item.byte_value} < 9'(SYMBOLS));
    end

    hcb_fifo #(.WIDTH($bits(hcb_pkg::t_job))) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_data  (w_job),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (w_qdata)
    );

    assign o_job = hcb_pkg::t_job'(w_qdata);
endmodule
`default_nettype wire

@@ hdl/hcb_engine.sv @@
// Back end: histogram, code construction, encode and table lookup.
`timescale 1ns / 1ps
`default_nettype none
module hcb_engine #(
    parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF,
    parameter int SYMBOLS       = hcb_pkg::SYMBOLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_empty,
    input  hcb_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output hcb_pkg::t_out o_res
);
    localparam int SA    = $clog2(SYMBOLS);
    localparam int NA    = SA + 1;
    localparam int NODES = 2 * SYMBOLS - 1;
    localparam int CB    = COUNT_BITS;
    localparam int WW    = COUNT_BITS + 8;
    localparam int DW    = hcb_pkg::DEP_W;
    localparam int CW    = hcb_pkg::CODE_W;
    localparam int TW    = COUNT_BITS + hcb_pkg::DEP_W;

    hcb_pkg::t_state r_state, n_state;
    hcb_pkg::t_job   r_job, n_job;
    hcb_pkg::t_out   r_res, n_res;
    logic                     r_built, n_built;
    logic [NA-1:0]            r_n, n_n;
    logic [hcb_pkg::PAY_W-1:0] r_pay, n_pay, r_acc, n_acc;
    logic [SA-1:0]            r_b, n_b, r_cd, n_cd, r_rank, n_rank;
    logic [NA-1:0]            r_c, n_c, r_lf, n_lf, r_nl, n_nl, r_cur, n_cur, r_i, n_i;
    logic                     r_cv, n_cv, r_bit, n_bit;
    logic [CB-1:0]            r_hb, n_hb;
    logic [WW-1:0]            r_w1, n_w1;
    logic [DW-1:0]            r_dep, n_dep;
    logic [TW-1:0]            r_term, n_term;
    logic [SYMBOLS-1:0]       r_hval;
    logic                     r_hv_q;

    logic               h_we;
    logic [SA-1:0]      h_waddr, h_raddr, l_waddr, l_raddr, c_waddr, c_raddr;
    logic [CB-1:0]      h_wdata, h_q, hdata;
    logic               l_we, c_we, w_we, p_we, dp_we;
    logic [7:0]         l_wdata, l_q;
    logic [hcb_pkg::LEN_W+CW-1:0] c_wdata, c_q;
    logic [NA-1:0]      w_waddr, wa_raddr, wb_raddr, p_waddr, p_raddr, dp_waddr, dp_raddr;
    logic [WW-1:0]      w_wdata, wa_q, wb_q, w_pickw;
    logic [NA:0]        p_wdata, p_q;
    logic [DW+CW-1:0]   dp_wdata, dp_q;
    logic [DW-1:0]      dep_q;
    logic [CW-1:0]      path_q;
    logic               w_take;
    logic [NA-1:0]      w_pick, w_last;
    logic [hcb_pkg::SUM_W-1:0] w_sum;
    logic [hcb_pkg::PAY_W-1:0] w_acc;

    assign hdata   = r_hv_q ? h_q : '0;
    assign dep_q   = dp_q[DW+CW-1:CW];
    assign path_q  = dp_q[CW-1:0];
    assign w_take  = (r_lf < r_n) && ((r_nl >= r_cur) || (wa_q < wb_q));
    assign w_pickw = w_take ? wa_q : wb_q;
    assign w_pick  = w_take ? r_lf : r_nl;
    assign w_last  = NA'({r_n, 1'b0} - 1'b1);
    assign w_sum   = hcb_pkg::SUM_W'(r_acc) + hcb_pkg::SUM_W'(r_term);
    assign w_acc   = (w_sum > hcb_pkg::SUM_W'(hcb_pkg::PAY_MAX)) ? hcb_pkg::PAY_MAX
                                                               : hcb_pkg::PAY_W'(w_sum);
    assign o_res   = r_res;

    always_comb begin
        n_state = r_state; n_job = r_job; n_res = r_res; n_built = r_built;
        n_n = r_n; n_pay = r_pay; n_acc = r_acc; n_b = r_b; n_cd = r_cd;
        n_rank = r_rank; n_c = r_c; n_lf = r_lf; n_nl = r_nl; n_cur = r_cur;
        n_i = r_i; n_cv = r_cv; n_bit = r_bit; n_hb = r_hb; n_w1 = r_w1;
        n_dep = r_dep; n_term = r_term;
        o_job_pop = 1'b0; o_res_push = 1'b0;
        h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; wa_raddr = '0; wb_raddr = '0;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
        dp_we = 1'b0; dp_waddr = '0; dp_wdata = '0; dp_raddr = '0;
        case (r_state)
            hcb_pkg::S_IDLE: begin
                if (!i_job_empty && (i_job.cmd == hcb_pkg::CMD_COUNT || !i_res_full)) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_res     = '0;
                    case (i_job.cmd)
                        hcb_pkg::CMD_COUNT: begin
                            n_state = i_job.in_range ? hcb_pkg::S_CNT_RD : hcb_pkg::S_IDLE;
                        end
                        hcb_pkg::CMD_BUILD: begin
                            n_n = '0; n_acc = '0; n_b = '0;
                            n_state = hcb_pkg::S_B_RD;
                        end
                        hcb_pkg::CMD_ENCODE: begin
                            n_res.symbol = i_job.byte_value;
                            if (!r_built) begin
                                n_res.status = hcb_pkg::STAT_NOT_BUILT;
                                n_state = hcb_pkg::S_EMIT;
                            end else if (!i_job.in_range) begin
                                n_res.alphabet_size = hcb_pkg::ALPHA_W'(r_n);
                                n_res.payload_bits  = r_pay;
                                n_res.status = hcb_pkg::STAT_ABSENT;
                                n_state = hcb_pkg::S_EMIT;
                            end else begin
                                n_state = hcb_pkg::S_E_RD;
                            end
                        end
                        hcb_pkg::CMD_READ: begin
                            if (!r_built) begin
                                n_res.status = hcb_pkg::STAT_NOT_BUILT;
                                n_state = hcb_pkg::S_EMIT;
                            end else if ({1'b0, i_job.entry_index} >= 9'(r_n)) begin
                                n_res.alphabet_size = hcb_pkg::ALPHA_W'(r_n);
                                n_res.payload_bits  = r_pay;
                                n_res.status = hcb_pkg::STAT_ABSENT;
                                n_state = hcb_pkg::S_EMIT;
                            end else begin
                                n_state = hcb_pkg::S_R_RD;
                            end
                        end
                        default: n_state = hcb_pkg::S_IDLE;
                    endcase
                end
            end
            hcb_pkg::S_CNT_RD: begin
                h_raddr = r_job.byte_value[SA-1:0];
                n_state = hcb_pkg::S_CNT_WR;
            end
            hcb_pkg::S_CNT_WR: begin
                h_we    = 1'b1;
                h_waddr = r_job.byte_value[SA-1:0];
                h_wdata = (hdata == {CB{1'b1}}) ? hdata : CB'(hdata + 1'b1);
                n_built = 1'b0;
                n_state = hcb_pkg::S_IDLE;
            end
            hcb_pkg::S_E_RD: begin
                h_raddr = r_job.byte_value[SA-1:0];
                c_raddr = r_job.byte_value[SA-1:0];
                n_state = hcb_pkg::S_E_GO;
            end
            hcb_pkg::S_E_GO: begin
                n_res.alphabet_size = hcb_pkg::ALPHA_W'(r_n);
                n_res.payload_bits  = r_pay;
                if (hdata == '0) begin
                    n_res.status = hcb_pkg::STAT_ABSENT;
                end else begin
                    n_res.code_length = c_q[hcb_pkg::LEN_W+CW-1:CW];
                    n_res.code_bits   = c_q[CW-1:0];
                    n_res.status      = hcb_pkg::STAT_OK;
                end
                n_state = hcb_pkg::S_EMIT;
            end
            hcb_pkg::S_R_RD: begin
                l_raddr = r_job.entry_index[SA-1:0];
                n_state = hcb_pkg::S_R_S;
            end
            hcb_pkg::S_R_S: begin
                c_raddr = l_q[SA-1:0];
                n_res.symbol = l_q;
                n_state = hcb_pkg::S_R_C;
            end
            hcb_pkg::S_R_C: begin
                n_res.code_length   = c_q[hcb_pkg::LEN_W+CW-1:CW];
                n_res.code_bits     = c_q[CW-1:0];
                n_res.alphabet_size = hcb_pkg::ALPHA_W'(r_n);
                n_res.payload_bits  = r_pay;
                n_res.status        = hcb_pkg::STAT_OK;
                n_state = hcb_pkg::S_EMIT;
            end
            hcb_pkg::S_B_RD: begin
                h_raddr = r_b;
                n_state = hcb_pkg::S_B_CHK;
            end
            hcb_pkg::S_B_CHK: begin
                if (hdata == '0) begin
                    if (r_b == SA'(SYMBOLS - 1)) begin
                        n_state = hcb_pkg::S_M_INIT;
                    end else begin
                        n_b = r_b + 1'b1;
                        n_state = hcb_pkg::S_B_RD;
                    end
                end else begin
                    n_hb = hdata; n_c = '0; n_cv = 1'b0; n_rank = '0;
                    n_state = hcb_pkg::S_C_RUN;
                end
            end
            hcb_pkg::S_C_RUN: begin
                if (r_cv && hdata != '0 &&
                    (hdata < r_hb || (hdata == r_hb && r_cd < r_b))) begin
                    n_rank = r_rank + 1'b1;
                end
                if (r_c == NA'(SYMBOLS)) begin
                    n_cv = 1'b0;
                    n_state = hcb_pkg::S_B_WR;
                end else begin
                    h_raddr = r_c[SA-1:0];
                    n_cd = r_c[SA-1:0];
                    n_cv = 1'b1;
                    n_c  = r_c + 1'b1;
                end
            end
            hcb_pkg::S_B_WR: begin
                l_we = 1'b1; l_waddr = r_rank; l_wdata = 8'(r_b);
                w_we = 1'b1; w_waddr = NA'(r_rank); w_wdata = WW'(r_hb);
                n_n = r_n + 1'b1;
                if (r_b == SA'(SYMBOLS - 1)) begin
                    n_state = hcb_pkg::S_M_INIT;
                end else begin
                    n_b = r_b + 1'b1;
                    n_state = hcb_pkg::S_B_RD;
                end
            end
            hcb_pkg::S_M_INIT: begin
                if (r_n == '0) begin
                    n_built = 1'b1; n_pay = '0;
                    n_res.status = hcb_pkg::STAT_OK;
                    n_state = hcb_pkg::S_EMIT;
                end else begin
                    n_lf = '0; n_nl = r_n; n_cur = r_n;
                    n_state = (r_n == NA'(1)) ? hcb_pkg::S_D_INIT : hcb_pkg::S_M_RD;
                end
            end
            hcb_pkg::S_M_RD, hcb_pkg::S_M_RD2: begin
                wa_raddr = r_lf;
                wb_raddr = r_nl;
                n_state = (r_state == hcb_pkg::S_M_RD) ? hcb_pkg::S_M_A : hcb_pkg::S_M_B;
            end
            hcb_pkg::S_M_A, hcb_pkg::S_M_B: begin
                p_we = 1'b1;
                p_waddr = w_pick;
                p_wdata = {r_cur, (r_state == hcb_pkg::S_M_A)};
                if (w_take) begin
                    n_lf = r_lf + 1'b1;
                end else begin
                    n_nl = r_nl + 1'b1;
                end
                if (r_state == hcb_pkg::S_M_A) begin
                    n_w1 = w_pickw;
                    n_state = hcb_pkg::S_M_RD2;
                end else begin
                    w_we = 1'b1; w_waddr = r_cur; w_wdata = WW'(r_w1 + w_pickw);
                    n_cur = r_cur + 1'b1;
                    n_state = (NA'(r_cur + 1'b1) == w_last) ? hcb_pkg::S_D_INIT
                                                          : hcb_pkg::S_M_RD;
                end
            end
            hcb_pkg::S_D_INIT: begin
                dp_we = 1'b1; dp_waddr = r_cur - 1'b1; dp_wdata = '0;
                n_i = r_cur - 1'b1;
                n_state = (r_cur == NA'(1)) ? hcb_pkg::S_L_RD : hcb_pkg::S_D_RD;
            end
            hcb_pkg::S_D_RD: begin
                p_raddr = r_i - 1'b1;
                n_i = r_i - 1'b1;
                n_state = hcb_pkg::S_D_P;
            end
            hcb_pkg::S_D_P: begin
                dp_raddr = p_q[NA:1];
                n_bit = p_q[0];
                n_state = hcb_pkg::S_D_Q;
            end
            hcb_pkg::S_D_Q: begin
                dp_we = 1'b1; dp_waddr = r_i;
                dp_wdata = {DW'(dep_q + 1'b1), path_q[CW-2:0], r_bit};
                n_state = (r_i == '0) ? hcb_pkg::S_L_RD : hcb_pkg::S_D_RD;
            end
            hcb_pkg::S_L_RD: begin
                l_raddr = r_i[SA-1:0];
                dp_raddr = r_i;
                n_state = hcb_pkg::S_L_S;
            end
            hcb_pkg::S_L_S: begin
                if (dep_q > DW'(MAX_CODE_BITS)) begin
                    n_built = 1'b0; n_pay = '0;
                    n_res.alphabet_size = hcb_pkg::ALPHA_W'(r_n);
                    n_res.status = hcb_pkg::STAT_NOT_BUILT;
                    n_state = hcb_pkg::S_EMIT;
                end else begin
                    c_we = 1'b1; c_waddr = l_q[SA-1:0];
                    c_wdata = {hcb_pkg::LEN_W'(dep_q), path_q};
                    h_raddr = l_q[SA-1:0];
                    n_dep = dep_q;
                    n_state = hcb_pkg::S_L_H;
                end
            end
            hcb_pkg::S_L_H: begin
                n_term = TW'(hdata) * TW'(r_dep);
                n_state = hcb_pkg::S_L_ADD;
            end
            hcb_pkg::S_L_ADD: begin
                n_acc = w_acc;
                if (NA'(r_i + 1'b1) == r_n) begin
                    n_built = 1'b1; n_pay = w_acc;
                    n_res.alphabet_size = hcb_pkg::ALPHA_W'(r_n);
                    n_res.payload_bits  = w_acc;
                    n_res.status = hcb_pkg::STAT_OK;
                    n_state = hcb_pkg::S_EMIT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = hcb_pkg::S_L_RD;
                end
            end
            hcb_pkg::S_EMIT: begin
                o_res_push = 1'b1;
                n_state = hcb_pkg::S_IDLE;
            end
            default: n_state = hcb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcb_pkg::S_IDLE;
            r_built <= 1'b0;
            r_n     <= '0;
            r_pay   <= '0;
            r_hval  <= '0;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_built <= n_built;
            r_n     <= n_n;
            r_pay   <= n_pay;
            r_cv    <= n_cv;
            if (h_we) begin
                r_hval[h_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_res <= n_res; r_acc <= n_acc; r_b <= n_b; r_cd <= n_cd;
        r_rank <= n_rank; r_c <= n_c; r_lf <= n_lf; r_nl <= n_nl; r_cur <= n_cur;
        r_i <= n_i; r_bit <= n_bit; r_hb <= n_hb; r_w1 <= n_w1; r_dep <= n_dep;
        r_term <= n_term;
        r_hv_q <= r_hval[h_raddr];
    end

    hcb_ram #(.WIDTH(CB), .DEPTH(SYMBOLS)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_q));
    hcb_ram #(.WIDTH(8), .DEPTH(SYMBOLS)) u_leaf (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_q));
    hcb_ram #(.WIDTH(hcb_pkg::LEN_W + CW), .DEPTH(SYMBOLS)) u_code (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_q));
    hcb_ram #(.WIDTH(WW), .DEPTH(NODES)) u_wgt_a (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(wa_raddr), .o_rdata(wa_q));
    hcb_ram #(.WIDTH(WW), .DEPTH(NODES)) u_wgt_b (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(wb_raddr), .o_rdata(wb_q));
    hcb_ram #(.WIDTH(NA + 1), .DEPTH(NODES)) u_par (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_q));
    hcb_ram #(.WIDTH(DW + CW), .DEPTH(NODES)) u_path (
        .i_clk(i_clk), .i_we(dp_we), .i_waddr(dp_waddr), .i_wdata(dp_wdata),
        .i_raddr(dp_raddr), .o_rdata(dp_q));
endmodule
`default_nettype wire

@@ hdl/huffman_code_builder_encoder.sv @@
// Top level of the static byte Huffman code builder and encoder.
`timescale 1ns / 1ps
`default_nettype none
// Commands enter through a two-entry input queue and results leave through a
// two-entry output queue; the engine between them runs one command at a time.
// Counts, encodes and table reads go through the registered read of the histogram,
// leaf and code memories. A build first runs a stable sort that ranks every
// present byte against the whole histogram through its single read port, then
// the merge, path and code passes walk the node memories.
// The histogram clears at reset at once; no clearing pass is needed.
module huffman_code_builder_encoder #(
    parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF,
    parameter int SYMBOLS       = hcb_pkg::SYMBOLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  hcb_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output hcb_pkg::t_out o_result
);
    hcb_pkg::t_job w_job;
    hcb_pkg::t_out w_res;
    logic          w_job_empty, w_job_pop, w_res_push, w_res_full;
    logic [$bits(hcb_pkg::t_out)-1:0] w_res_q;

    hcb_front #(.SYMBOLS(SYMBOLS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_item), .i_pop(w_job_pop), .o_empty(w_job_empty), .o_job(w_job));

    hcb_engine #(
        .COUNT_BITS(COUNT_BITS), .MAX_CODE_BITS(MAX_CODE_BITS), .SYMBOLS(SYMBOLS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_empty(w_job_empty), .i_job(w_job),
        .o_job_pop(w_job_pop), .i_res_full(w_res_full), .o_res_push(w_res_push),
        .o_res(w_res));

    hcb_fifo #(.WIDTH($bits(hcb_pkg::t_out))) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_res_push), .o_full(w_res_full),
        .i_data(w_res), .i_pop(pop), .o_empty(empty), .o_data(w_res_q));

    assign o_result = hcb_pkg::t_out'(w_res_q);

    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full) else $error("result queue overflow");

    a_no_job_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_job_empty) else $error("job taken from empty queue");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status == hcb_pkg::STAT_OK ||
                    o_result.status == hcb_pkg::STAT_ABSENT ||
                    o_result.status == hcb_pkg::STAT_NOT_BUILT))
        else $error("bad status code");

    a_not_built_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == hcb_pkg::STAT_NOT_BUILT) |->
        (o_result.code_length == '0 && o_result.payload_bits == '0))
        else $error("not-built result carries code data");
endmodule
`default_nettype wire

@@ tb/sv/tb_huffman_code_builder_encoder.sv @@
// Testbench for the Huffman code builder and encoder against a transaction predictor.
`timescale 1ns / 1ps

class huff_scoreboard;
    logic [63:0]   hist [256];
    logic [7:0]    leaf_sym [256];
    bit            present [256];
    logic [63:0]   code_tab [256];
    int            len_tab [256];
    int            n_leaves;
    bit            built;
    logic [46:0]   pay_total;
    hcb_pkg::t_out pending [$];
    int            mismatches;

    function new();
        foreach (hist[b]) begin
            hist[b] = '0;
            present[b] = 0;
        end
        n_leaves = 0;
        built = 0;
        pay_total = '0;
        mismatches = 0;
    endfunction

    function logic [1:0] build_codes();
        logic [63:0] weight [511];
        int          parent [511];
        bit          bitv [511];
        int          depth [511];
        logic [63:0] path [511];
        int n, i, j, lf, nl, cur, a, c, s;
        logic [63:0] term;
        logic [46:0] pay;
        n = 0;
        pay = '0;
        for (int b = 0; b < 256; b++) begin
            present[b] = 0;
            if (hist[b] == 0) continue;
            j = n;
            while (j > 0 && hist[leaf_sym[j-1]] > hist[b]) begin
                leaf_sym[j] = leaf_sym[j-1];
                j--;
            end
            leaf_sym[j] = b[7:0];
            present[b] = 1;
            n++;
        end
        n_leaves = n;
        if (n == 0) begin
            pay_total = '0;
            built = 1;
            return hcb_pkg::STAT_OK;
        end
        for (i = 0; i < n; i++) weight[i] = hist[leaf_sym[i]];
        lf = 0;
        nl = n;
        cur = n;
        for (i = 0; i + 1 < n; i++) begin
            if (lf < n && (nl >= cur || weight[lf] < weight[nl])) begin
                a = lf;
                lf++;
            end else begin
                a = nl;
                nl++;
            end
            if (lf < n && (nl >= cur || weight[lf] < weight[nl])) begin
                c = lf;
                lf++;
            end else begin
                c = nl;
                nl++;
            end
            weight[cur] = weight[a] + weight[c];
            parent[a] = cur;
            parent[c] = cur;
            bitv[a] = 1;
            bitv[c] = 0;
            cur++;
        end
        depth[cur-1] = 0;
        path[cur-1] = '0;
        for (i = cur - 2; i >= 0; i--) begin
            depth[i] = depth[parent[i]] + 1;
            path[i] = (path[parent[i]] << 1) | bitv[i];
        end
        for (i = 0; i < n; i++) begin
            s = leaf_sym[i];
            if (depth[i] > 64) begin
                built = 0;
                pay_total = '0;
                return hcb_pkg::STAT_NOT_BUILT;
            end
            code_tab[s] = path[i];
            len_tab[s] = depth[i];
            term = hist[s] * depth[i];
            if (term > {17'd0, hcb_pkg::PAY_MAX} - {17'd0, pay}) pay = hcb_pkg::PAY_MAX;
            else pay = pay + term[46:0];
        end
        pay_total = pay;
        built = 1;
        return hcb_pkg::STAT_OK;
    endfunction

    function void note_input(hcb_pkg::t_in x);
        hcb_pkg::t_out r;
        int            s;
        r = '0;
        case (hcb_pkg::t_cmd'(x.command))
            hcb_pkg::CMD_COUNT: begin
                if (hist[x.byte_value] < 64'hFFFF_FFFF) hist[x.byte_value]++;
                built = 0;
                return;
            end
            hcb_pkg::CMD_BUILD: begin
                r.status = build_codes();
                r.alphabet_size = n_leaves[8:0];
                r.payload_bits = pay_total;
            end
            hcb_pkg::CMD_ENCODE: begin
                r.symbol = x.byte_value;
                if (!built) r.status = hcb_pkg::STAT_NOT_BUILT;
                else begin
                    r.alphabet_size = n_leaves[8:0];
                    r.payload_bits = pay_total;
                    if (!present[x.byte_value]) r.status = hcb_pkg::STAT_ABSENT;
                    else begin
                        r.code_length = len_tab[x.byte_value][6:0];
                        r.code_bits = code_tab[x.byte_value];
                        r.status = hcb_pkg::STAT_OK;
                    end
                end
            end
            default: begin
                if (!built) r.status = hcb_pkg::STAT_NOT_BUILT;
                else begin
                    r.alphabet_size = n_leaves[8:0];
                    r.payload_bits = pay_total;
                    if (x.entry_index >= n_leaves) r.status = hcb_pkg::STAT_ABSENT;
                    else begin
                        s = leaf_sym[x.entry_index];
                        r.symbol = s[7:0];
                        r.code_length = len_tab[s][6:0];
                        r.code_bits = code_tab[s];
                        r.status = hcb_pkg::STAT_OK;
                    end
                end
            end
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(hcb_pkg::t_out got);
        hcb_pkg::t_out want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.symbol !== want.symbol || got.code_length !== want.code_length ||
            got.code_bits !== want.code_bits || got.alphabet_size !== want.alphabet_size ||
            got.payload_bits !== want.payload_bits || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected sym %h len %0d code %h alpha %0d pay %0d st %0d",
                         want.symbol, want.code_length, want.code_bits,
                         want.alphabet_size, want.payload_bits, want.status);
                $display("          got      sym %h len %0d code %h alpha %0d pay %0d st %0d",
                         got.symbol, got.code_length, got.code_bits,
                         got.alphabet_size, got.payload_bits, got.status);
            end
        end
    endfunction
endclass

module tb_huffman_code_builder_encoder;
    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    hcb_pkg::t_in  i_item;
    logic          empty;
    logic          pop = 1'b0;
    hcb_pkg::t_out o_result;

    huff_scoreboard sb;
    int   sent;
    int   burst_left;
    int   stall_mode = 0;
    int   stall_left = 0;
    logic [7:0] pool [16];

    huffman_code_builder_encoder i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("tb_huffman_code_builder_encoder: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_result);
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send(input hcb_pkg::t_cmd cmd, input logic [7:0] bv,
                        input logic [7:0] idx);
        hcb_pkg::t_in x;
        x.command = cmd;
        x.byte_value = bv;
        x.entry_index = idx;
        i_item <= x;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(x);
        sent++;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    task automatic encode_and_read(input int count);
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: send(hcb_pkg::CMD_ENCODE, pool[$urandom_range(0, 15)], 8'd0);
                1: send(hcb_pkg::CMD_ENCODE, 8'($urandom_range(0, 255)), 8'd0);
                2: send(hcb_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 20)));
                default: send(hcb_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        int perm [256];
        int j, tmp;
        sb = new();
        sent = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        pool[0] = 8'h00;
        pool[1] = 8'hFF;
        foreach (pool[k]) if (k > 1) pool[k] = 8'($urandom_range(0, 255));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(hcb_pkg::CMD_ENCODE, 8'hFF, 8'hFF);
        send(hcb_pkg::CMD_READ, 8'h00, 8'h00);
        send(hcb_pkg::CMD_BUILD, 8'h00, 8'h00);
        send(hcb_pkg::CMD_ENCODE, 8'h00, 8'h00);
        send(hcb_pkg::CMD_READ, 8'hFF, 8'h00);
        send(hcb_pkg::CMD_COUNT, 8'hFF, 8'hFF);
        send(hcb_pkg::CMD_ENCODE, 8'hFF, 8'h00);
        send(hcb_pkg::CMD_BUILD, 8'hFF, 8'hFF);
        send(hcb_pkg::CMD_ENCODE, 8'hFF, 8'h00);
        send(hcb_pkg::CMD_READ, 8'h00, 8'h00);
        send(hcb_pkg::CMD_READ, 8'h00, 8'h01);
        send(hcb_pkg::CMD_COUNT, 8'h00, 8'h00);
        send(hcb_pkg::CMD_COUNT, 8'h00, 8'h00);
        send(hcb_pkg::CMD_COUNT, pool[2], 8'h00);
        send(hcb_pkg::CMD_BUILD, 8'h00, 8'h00);
        send(hcb_pkg::CMD_ENCODE, 8'h00, 8'h00);
        send(hcb_pkg::CMD_ENCODE, pool[2], 8'h00);
        send(hcb_pkg::CMD_READ, 8'h00, 8'h02);
        send(hcb_pkg::CMD_READ, 8'h00, 8'hFF);
        send(hcb_pkg::CMD_COUNT, 8'h00, 8'h00);
        send(hcb_pkg::CMD_READ, 8'h00, 8'h00);

        while (sent < 840) begin
            repeat ($urandom_range(1, 30)) begin
                if ($urandom_range(0, 19) == 0)
                    send(hcb_pkg::CMD_COUNT, 8'($urandom_range(0, 255)), 8'd0);
                else
                    send(hcb_pkg::CMD_COUNT, pool[$urandom_range(0, 15)],
                         8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) < 7)
                send(hcb_pkg::CMD_BUILD, 8'($urandom_range(0, 255)), 8'd0);
            encode_and_read($urandom_range(3, 20));
        end

        foreach (perm[k]) perm[k] = k;
        for (int k = 255; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        foreach (perm[k]) send(hcb_pkg::CMD_COUNT, 8'(perm[k]), 8'd0);
        send(hcb_pkg::CMD_BUILD, 8'd0, 8'd0);
        encode_and_read(40);
        send(hcb_pkg::CMD_READ, 8'd0, 8'hFF);
        send(hcb_pkg::CMD_ENCODE, 8'h7F, 8'd0);
        push <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_huffman_code_builder_encoder: PASS");
        else
            $display("tb_huffman_code_builder_encoder: FAIL");
        $finish;
    end
endmodule
